// File: rtl/sxu_pkg.sv
// sxu_pkg: widths, item types and stage records for the segment intersection unit
// used by every module of the block; no dependencies
`default_nettype none

package sxu_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DIF_BITS   = COORD_BITS + 1;
   localparam int PRD_BITS   = 2 * DIF_BITS;
   localparam int CRS_BITS   = PRD_BITS + 1;
   localparam int MAG_BITS   = PRD_BITS;
   localparam int NUM_BITS   = MAG_BITS + COORD_BITS + FRAC_BITS;
   localparam int QUO_BITS   = OUT_BITS;
   localparam int FRONT_STAGES = 5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_start_x;
      logic signed [COORD_BITS-1:0] a_start_y;
      logic signed [COORD_BITS-1:0] a_end_x;
      logic signed [COORD_BITS-1:0] a_end_y;
      logic signed [COORD_BITS-1:0] b_start_x;
      logic signed [COORD_BITS-1:0] b_start_y;
      logic signed [COORD_BITS-1:0] b_end_x;
      logic signed [COORD_BITS-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                       hit;
      logic signed [OUT_BITS-1:0] cross_x;
      logic signed [OUT_BITS-1:0] cross_y;
   } rsp_type;

   // handoff from the geometry front end to the divider
   typedef struct packed {
      logic                hit;
      logic                neg_x;
      logic                neg_y;
      logic [NUM_BITS-1:0] num_x;
      logic [NUM_BITS-1:0] num_y;
      logic [MAG_BITS-1:0] den;
      logic [OUT_BITS-1:0] base_x;
      logic [OUT_BITS-1:0] base_y;
   } div_in_type;

   typedef struct packed {
      logic                hit;
      logic                neg_x;
      logic                neg_y;
      logic [QUO_BITS-1:0] quo_x;
      logic [QUO_BITS-1:0] quo_y;
      logic [OUT_BITS-1:0] base_x;
      logic [OUT_BITS-1:0] base_y;
   } div_out_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] rem;
      logic [QUO_BITS-1:0] lo;
      logic [QUO_BITS-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                hit;
      logic                neg_x;
      logic                neg_y;
      logic [MAG_BITS-1:0] den;
      logic [OUT_BITS-1:0] base_x;
      logic [OUT_BITS-1:0] base_y;
      div_lane_type        lane_x;
      div_lane_type        lane_y;
   } div_stage_type;

endpackage

`default_nettype wire

// File: rtl/segment_intersection_unit.sv
// segment_intersection_unit: top level, front end, divider and output register
// depends on sxu_pkg, sxu_front, sxu_divider
`default_nettype none

// Tests whether segment a (a_start to a_end) and segment b (b_start to b_end)
// cross and gives the crossing point a_start + t*(a_end - a_start) with
// FRAC_BITS fraction bits, the fraction truncated toward zero. The test is
// exact integer math: parallel, collinear or zero-length segments never hit,
// touching at an endpoint does. With no hit both coordinates read zero.
// The block is a pipeline that takes one item per clock while req_stall is
// low; each item passes five front-end stages for differences, products,
// cross terms, hit test and numerator scaling, 24 divider stages that each
// resolve one quotient bit, and the output register. Bubbles collapse under
// a stall, so the input keeps taking items until the pipe is full behind a
// stalled result.

module segment_intersection_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sxu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sxu_pkg::rsp_type      rsp_data
);
   import sxu_pkg::*;

   logic       front_ready;
   logic       mid_valid;
   div_in_type mid_data;
   logic       mid_ready;
   logic        div_valid;
   div_out_type div_data;
   logic        div_ready;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic [OUT_BITS-1:0] off_x, off_y;

   // geometry front end
   sxu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (front_ready),
      .out_valid (mid_valid),
      .out_data  (mid_data),
      .out_ready (mid_ready)
   );

   // quotient of scaled numerator by denominator magnitude
   sxu_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_data   (mid_data),
      .in_ready  (mid_ready),
      .out_valid (div_valid),
      .out_data  (div_data),
      .out_ready (div_ready)
   );

   assign req_stall = !front_ready;

   // output register frees up when empty or when its item is taken
   assign div_ready = !rsp_valid_ff || !rsp_stall;

   // apply sign to the quotient and add the scaled start point, zero on miss
   always_comb begin
      off_x = div_data.neg_x ? -div_data.quo_x : div_data.quo_x;
      off_y = div_data.neg_y ? -div_data.quo_y : div_data.quo_y;
      rsp_data_in.hit = div_data.hit;
      if (div_data.hit) begin
         rsp_data_in.cross_x = div_data.base_x + off_x;
         rsp_data_in.cross_y = div_data.base_y + off_y;
      end else begin
         rsp_data_in.cross_x = '0;
         rsp_data_in.cross_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/sxu_front.sv
// sxu_front: five-stage front end: differences, products, cross terms, hit test, numerators
// depends on sxu_pkg
`default_nettype none

module sxu_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire sxu_pkg::req_type   in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output sxu_pkg::div_in_type     out_data,
   input  wire logic               out_ready
);
   import sxu_pkg::*;

   logic [FRONT_STAGES-1:0] vld_ff;
   logic [FRONT_STAGES-1:0] en;

   // stage 1: direction and offset differences
   logic signed [DIF_BITS-1:0] rx_ff, ry_ff, sx_ff, sy_ff, wx_ff, wy_ff;
   logic [OUT_BITS-1:0] bx1_ff, by1_ff;
   // stage 2: products
   logic signed [PRD_BITS-1:0] p_rs_ff, p_rs2_ff, p_ws_ff, p_ws2_ff, p_wr_ff, p_wr2_ff;
   logic signed [DIF_BITS-1:0] rx2_ff, ry2_ff;
   logic [OUT_BITS-1:0] bx2_ff, by2_ff;
   // stage 3: denominator and numerators
   logic signed [CRS_BITS-1:0] d_ff, tn_ff, un_ff;
   logic signed [DIF_BITS-1:0] rx3_ff, ry3_ff;
   logic [OUT_BITS-1:0] bx3_ff, by3_ff;
   // stage 4: hit test and magnitudes
   logic hit4_ff, negx4_ff, negy4_ff;
   logic [MAG_BITS-1:0] tn4_ff, d4_ff;
   logic [COORD_BITS-1:0] rx4_ff, ry4_ff;
   logic [OUT_BITS-1:0] bx4_ff, by4_ff;
   // stage 5: scaled numerators
   div_in_type out_ff;

   logic signed [CRS_BITS-1:0] tn_abs, d_abs;
   logic signed [DIF_BITS-1:0] rx_abs, ry_abs;
   logic hit_in;
   logic [MAG_BITS+COORD_BITS-1:0] prod_x, prod_y;

   always_comb begin
      en[FRONT_STAGES-1] = !vld_ff[FRONT_STAGES-1] || out_ready;
      for (int k = FRONT_STAGES-2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_data  = out_ff;

   always_comb begin
      tn_abs = (tn_ff < 0) ? -tn_ff : tn_ff;
      d_abs  = (d_ff < 0) ? -d_ff : d_ff;
      rx_abs = (rx3_ff < 0) ? -rx3_ff : rx3_ff;
      ry_abs = (ry3_ff < 0) ? -ry3_ff : ry3_ff;
      if (d_ff > 0) begin
         hit_in = (tn_ff >= 0) && (tn_ff <= d_ff) && (un_ff >= 0) && (un_ff <= d_ff);
      end else if (d_ff < 0) begin
         hit_in = (tn_ff <= 0) && (tn_ff >= d_ff) && (un_ff <= 0) && (un_ff >= d_ff);
      end else begin
         hit_in = 1'b0;
      end
      prod_x = tn4_ff * rx4_ff;
      prod_y = tn4_ff * ry4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < FRONT_STAGES; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rx_ff  <= DIF_BITS'(in_data.a_end_x) - DIF_BITS'(in_data.a_start_x);
         ry_ff  <= DIF_BITS'(in_data.a_end_y) - DIF_BITS'(in_data.a_start_y);
         sx_ff  <= DIF_BITS'(in_data.b_end_x) - DIF_BITS'(in_data.b_start_x);
         sy_ff  <= DIF_BITS'(in_data.b_end_y) - DIF_BITS'(in_data.b_start_y);
         wx_ff  <= DIF_BITS'(in_data.b_start_x) - DIF_BITS'(in_data.a_start_x);
         wy_ff  <= DIF_BITS'(in_data.b_start_y) - DIF_BITS'(in_data.a_start_y);
         bx1_ff <= OUT_BITS'(in_data.a_start_x) << FRAC_BITS;
         by1_ff <= OUT_BITS'(in_data.a_start_y) << FRAC_BITS;
      end
      if (en[1]) begin
         p_rs_ff  <= rx_ff * sy_ff;
         p_rs2_ff <= ry_ff * sx_ff;
         p_ws_ff  <= wx_ff * sy_ff;
         p_ws2_ff <= wy_ff * sx_ff;
         p_wr_ff  <= wx_ff * ry_ff;
         p_wr2_ff <= wy_ff * rx_ff;
         rx2_ff   <= rx_ff;
         ry2_ff   <= ry_ff;
         bx2_ff   <= bx1_ff;
         by2_ff   <= by1_ff;
      end
      if (en[2]) begin
         d_ff   <= CRS_BITS'(p_rs_ff) - CRS_BITS'(p_rs2_ff);
         tn_ff  <= CRS_BITS'(p_ws_ff) - CRS_BITS'(p_ws2_ff);
         un_ff  <= CRS_BITS'(p_wr_ff) - CRS_BITS'(p_wr2_ff);
         rx3_ff <= rx2_ff;
         ry3_ff <= ry2_ff;
         bx3_ff <= bx2_ff;
         by3_ff <= by2_ff;
      end
      if (en[3]) begin
         hit4_ff  <= hit_in;
         negx4_ff <= (tn_ff < 0) ^ (rx3_ff < 0) ^ (d_ff < 0);
         negy4_ff <= (tn_ff < 0) ^ (ry3_ff < 0) ^ (d_ff < 0);
         tn4_ff   <= tn_abs[MAG_BITS-1:0];
         d4_ff    <= d_abs[MAG_BITS-1:0];
         rx4_ff   <= rx_abs[COORD_BITS-1:0];
         ry4_ff   <= ry_abs[COORD_BITS-1:0];
         bx4_ff   <= bx3_ff;
         by4_ff   <= by3_ff;
      end
      if (en[4]) begin
         out_ff.hit    <= hit4_ff;
         out_ff.neg_x  <= negx4_ff;
         out_ff.neg_y  <= negy4_ff;
         out_ff.num_x  <= NUM_BITS'(prod_x) << FRAC_BITS;
         out_ff.num_y  <= NUM_BITS'(prod_y) << FRAC_BITS;
         out_ff.den    <= d4_ff;
         out_ff.base_x <= bx4_ff;
         out_ff.base_y <= by4_ff;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sxu_divider.sv
// sxu_divider: pipelined restoring divider, one quotient bit per stage, x and y lanes
// depends on sxu_pkg
`default_nettype none

module sxu_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire sxu_pkg::div_in_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output sxu_pkg::div_out_type    out_data,
   input  wire logic               out_ready
);
   import sxu_pkg::*;

   logic [QUO_BITS-1:0] vld_ff;
   logic [QUO_BITS-1:0] en;
   div_stage_type stage_ff [QUO_BITS];
   div_stage_type stage_in [QUO_BITS];
   div_stage_type head;

   function automatic div_lane_type div_step(div_lane_type prev, logic [MAG_BITS-1:0] den);
      logic [MAG_BITS:0] trial;
      logic              ge;
      div_lane_type      nxt;
      trial   = {prev.rem, prev.lo[QUO_BITS-1]};
      ge      = trial >= {1'b0, den};
      nxt.rem = ge ? MAG_BITS'(trial - {1'b0, den}) : trial[MAG_BITS-1:0];
      nxt.lo  = prev.lo << 1;
      nxt.quo = {prev.quo[QUO_BITS-2:0], ge};
      return nxt;
   endfunction

   always_comb begin
      en[QUO_BITS-1] = !vld_ff[QUO_BITS-1] || out_ready;
      for (int k = QUO_BITS-2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_comb begin
      head.hit         = in_data.hit;
      head.neg_x       = in_data.neg_x;
      head.neg_y       = in_data.neg_y;
      head.den         = in_data.den;
      head.base_x      = in_data.base_x;
      head.base_y      = in_data.base_y;
      head.lane_x.rem  = in_data.num_x[NUM_BITS-1:QUO_BITS];
      head.lane_x.lo   = in_data.num_x[QUO_BITS-1:0];
      head.lane_x.quo  = '0;
      head.lane_y.rem  = in_data.num_y[NUM_BITS-1:QUO_BITS];
      head.lane_y.lo   = in_data.num_y[QUO_BITS-1:0];
      head.lane_y.quo  = '0;
      for (int k = 0; k < QUO_BITS; k++) begin
         stage_in[k] = (k == 0) ? head : stage_ff[(k == 0) ? 0 : k-1];
         stage_in[k].lane_x = div_step(stage_in[k].lane_x, stage_in[k].den);
         stage_in[k].lane_y = div_step(stage_in[k].lane_y, stage_in[k].den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < QUO_BITS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_BITS; k++) begin
         if (en[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign in_ready        = en[0];
   assign out_valid       = vld_ff[QUO_BITS-1];
   assign out_data.hit    = stage_ff[QUO_BITS-1].hit;
   assign out_data.neg_x  = stage_ff[QUO_BITS-1].neg_x;
   assign out_data.neg_y  = stage_ff[QUO_BITS-1].neg_y;
   assign out_data.quo_x  = stage_ff[QUO_BITS-1].lane_x.quo;
   assign out_data.quo_y  = stage_ff[QUO_BITS-1].lane_y.quo;
   assign out_data.base_x = stage_ff[QUO_BITS-1].base_x;
   assign out_data.base_y = stage_ff[QUO_BITS-1].base_y;

endmodule

`default_nettype wire
